### rtl/core/pcs_pkg.sv
package pcs_pkg;

    // fixed field widths
    localparam int W_CMD     = 1;
    localparam int W_NODE    = 8;
    localparam int W_PARENT  = 9;
    localparam int W_BRANCH  = 24;
    localparam int W_LEAF    = 8;
    localparam int W_CSET    = 4;
    localparam int W_RS      = 48;
    localparam int W_DEPTH   = 8;
    localparam int W_CFG_IDX = 2;
    localparam int W_CFG_DAT = 24;
    localparam int W_NCOUNT  = 9;
    localparam int W_MINLF   = 8;
    localparam int W_SCALE   = 24;
    localparam int FRAC_BITS = 16;
    localparam int NUM_BASES = 4;

    // command codes
    localparam logic [W_CMD-1:0] CMD_LOAD = 1'b0;
    localparam logic [W_CMD-1:0] CMD_LEAF = 1'b1;

    // register indexes
    localparam logic [W_CFG_IDX-1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [W_CFG_IDX-1:0] REG_LEAF_FLOOR = 2'd1;
    localparam logic [W_CFG_IDX-1:0] REG_LEN_MULT   = 2'd2;

    // register reset values
    localparam logic [W_NCOUNT-1:0] RST_NODE_COUNT = 9'd1;
    localparam logic [W_MINLF-1:0]  RST_LEAF_FLOOR = 8'd0;
    localparam logic [W_SCALE-1:0]  RST_LEN_MULT   = 24'd65536;

    typedef struct packed {
        logic [W_NCOUNT-1:0] node_count;
        logic [W_MINLF-1:0]  leaf_floor;
        logic [W_SCALE-1:0]  len_mult;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEAF_WR,
        ST_NODE_RD,
        ST_NODE_DAT,
        ST_EVAL,
        ST_FOLD,
        ST_CHECK,
        ST_SCORE,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_LO,
        SC_HI,
        SC_SUB,
        SC_DONE
    } t_score_st;

endpackage

### rtl/core/pcs_item_if.sv
interface pcs_item_if;
    import pcs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [W_CMD-1:0]           cmd;
    logic [W_NODE-1:0]          node_index;
    logic signed [W_PARENT-1:0] parent_index;
    logic [W_BRANCH-1:0]        branch_length;
    logic signed [W_LEAF-1:0]   leaf_id;
    logic [W_CSET-1:0]          leaf_cset;
    logic                       last;

    modport source (
        output valid, cmd, node_index, parent_index, branch_length, leaf_id,
               leaf_cset, last,
        input  ready
    );
    modport sink (
        input  valid, cmd, node_index, parent_index, branch_length, leaf_id,
               leaf_cset, last,
        output ready
    );
endinterface

### rtl/core/pcs_result_if.sv
interface pcs_result_if;
    import pcs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   scored;
    logic signed [W_RS-1:0] rs_score;
    logic [W_DEPTH-1:0]     depth;

    modport source (output valid, scored, rs_score, depth, input ready);
    modport sink (input valid, scored, rs_score, depth, output ready);
endinterface

### rtl/core/pcs_cfg_if.sv
interface pcs_cfg_if;
    import pcs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [W_CFG_IDX-1:0] index;
    logic [W_CFG_DAT-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/pcs_ram.sv
module pcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/pcs_cfg_regs.sv
module pcs_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcs_cfg_if.sink       i_cfg,
    output pcs_pkg::t_cfg o_cfg
);
    import pcs_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_count <= RST_NODE_COUNT;
            r_cfg.leaf_floor <= RST_LEAF_FLOOR;
            r_cfg.len_mult   <= RST_LEN_MULT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_NODE_COUNT: r_cfg.node_count <= i_cfg.data[W_NCOUNT-1:0];
                REG_LEAF_FLOOR: r_cfg.leaf_floor <= i_cfg.data[W_MINLF-1:0];
                REG_LEN_MULT:   r_cfg.len_mult   <= i_cfg.data[W_SCALE-1:0];
                default: ;
            endcase
        end
    end
endmodule

### rtl/core/pcs_score.sv
module pcs_score #(
    parameter int BSUM_W = 33,
    parameter int COST_W = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [BSUM_W-1:0]               i_bsum,
    input  logic [COST_W-1:0]               i_cost,
    input  logic [pcs_pkg::W_SCALE-1:0]     i_scale,
    output logic                            o_done,
    output logic [pcs_pkg::W_RS-1:0]        o_rs
);
    import pcs_pkg::*;

    localparam int HI_W = BSUM_W - W_BRANCH;

    t_score_st                  r_st;
    t_score_st                  n_st;
    logic [BSUM_W-1:0]          r_b;
    logic [COST_W-1:0]          r_c;
    logic [W_SCALE-1:0]         r_s;
    logic [W_BRANCH+W_SCALE-1:0] r_plo;
    logic [HI_W+W_SCALE-1:0]    r_phi;
    logic [W_RS-1:0]            r_rs;

    assign o_done = (r_st == SC_DONE);
    assign o_rs   = r_rs;

    // step sequence
    always_comb begin
        n_st = r_st;
        case (r_st)
            SC_IDLE: if (i_start) n_st = SC_LO;
            SC_LO:   n_st = SC_HI;
            SC_HI:   n_st = SC_SUB;
            SC_SUB:  n_st = SC_DONE;
            SC_DONE: n_st = SC_IDLE;
            default: n_st = SC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SC_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // partial products, low 24 bits then high bits of the branch sum
    always_ff @(posedge i_clk) begin
        case (r_st)
            SC_IDLE: begin
                if (i_start) begin
                    r_b <= i_bsum;
                    r_c <= i_cost;
                    r_s <= i_scale;
                end
            end
            SC_LO: r_plo <= r_b[W_BRANCH-1:0] * r_s;
            SC_HI: r_phi <= r_b[BSUM_W-1:W_BRANCH] * r_s;
            SC_SUB: begin
                r_rs <= W_RS'(r_plo >> FRAC_BITS)
                      + (W_RS'(r_phi) << (W_BRANCH - FRAC_BITS))
                      - (W_RS'(r_c) << FRAC_BITS);
            end
            default: ;
        endcase
    end
endmodule

### rtl/core/parsimony_conservation_scorer.sv
// load request: a node table write; leaf request: a read-modify-write of the leaf set memory
// last leaf request: a depth pass over the N nodes, a scoring pass over them, then the product; at N = 0 no pass runs
// below the leaf floor the scoring pass and product are skipped; N = node count
// node steps are bounded by the registered read ports of the memories; emit waits on o_res
// after each column, and after reset, a clear pass over max(MAX_NODES, MAX_LEAVES) addresses runs
// with no request accepted; i_rst_n is synchronous and active low, registers take reset values
module parsimony_conservation_scorer #(
    parameter int MAX_NODES  = 256,
    parameter int MAX_LEAVES = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcs_item_if.sink      i_item,
    pcs_cfg_if.sink       i_cfg,
    pcs_result_if.source  o_res
);
    import pcs_pkg::*;

    localparam int NA     = $clog2(MAX_NODES);
    localparam int LA     = $clog2(MAX_LEAVES);
    localparam int VC_W   = $clog2(MAX_NODES + 1);
    localparam int BSUM_W = W_BRANCH + VC_W;
    localparam int WK_W   = (NUM_BASES + 1) * VC_W;
    localparam int ND_W   = W_PARENT + W_BRANCH + W_LEAF;
    localparam int CD     = (MAX_NODES > MAX_LEAVES) ? MAX_NODES : MAX_LEAVES;
    localparam int CW     = $clog2(CD);

    t_cfg               cfg;
    logic [VC_W-1:0]    n_nodes;
    logic               accept;
    logic               lid_ok;

    t_state             r_state;
    t_state             n_state;
    logic [CW-1:0]      r_clr;
    logic [VC_W-1:0]    r_v;
    logic               r_pass2;
    logic [VC_W-1:0]    r_depth;
    logic [BSUM_W-1:0]  r_bsum;
    logic [VC_W-1:0]    r_cost;
    logic [LA-1:0]      r_lf_addr;
    logic [W_CSET-1:0]  r_lf_set;
    logic               r_lf_ok;
    logic               r_last;
    logic [W_PARENT-1:0] r_par;
    logic [W_BRANCH-1:0] r_br;
    logic [W_LEAF-1:0]  r_raw;
    logic [W_CSET-1:0]  r_cs;
    logic               r_ok;
    logic [W_RS-1:0]    r_rs;
    logic               r_out_valid;
    logic               r_out_scored;
    logic [W_RS-1:0]    r_out_rs;
    logic [W_DEPTH-1:0] r_out_depth;

    logic               nd_we;
    logic [NA-1:0]      nd_waddr;
    logic [ND_W-1:0]    nd_wdata;
    logic [NA-1:0]      nd_raddr;
    logic [ND_W-1:0]    nd_rdata;
    logic               lf_we;
    logic [LA-1:0]      lf_waddr;
    logic [W_CSET-1:0]  lf_wdata;
    logic [LA-1:0]      lf_raddr;
    logic [W_CSET-1:0]  lf_rdata;
    logic               wk_we;
    logic [NA-1:0]      wk_waddr;
    logic [WK_W-1:0]    wk_wdata;
    logic [NA-1:0]      wk_raddr;
    logic [WK_W-1:0]    wk_rdata;

    logic               is_leaf;
    logic [W_CSET-1:0]  cs_leaf;
    logic [VC_W-1:0]    wk_pc;
    logic [VC_W-1:0]    wk_vote [NUM_BASES];
    logic [VC_W-1:0]    mx;
    logic [W_CSET-1:0]  cs_int;
    logic [W_CSET-1:0]  cs_eval;
    logic               par_ok;
    logic               fold;
    logic               adv;
    logic               last_node;
    logic               depth_ok;
    logic               out_free;
    logic               sc_start;
    logic               sc_done;
    logic [W_RS-1:0]    sc_rs;

    pcs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // node count above the table size walks the whole table
    assign n_nodes = (32'(cfg.node_count) > MAX_NODES) ? VC_W'(MAX_NODES)
                                                       : VC_W'(cfg.node_count);

    assign i_item.ready = (r_state == ST_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign lid_ok       = !i_item.leaf_id[W_LEAF-1]
                          && (32'(i_item.leaf_id[W_LEAF-2:0]) < MAX_LEAVES);

    // node table: parent, branch, leaf id
    assign nd_we    = accept && (i_item.cmd == CMD_LOAD)
                      && (32'(i_item.node_index) < MAX_NODES);
    assign nd_waddr = NA'(i_item.node_index);
    assign nd_wdata = {i_item.parent_index, i_item.branch_length, i_item.leaf_id};
    assign nd_raddr = NA'(r_v);

    pcs_ram #(.WIDTH(ND_W), .DEPTH(MAX_NODES)) u_node_mem (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wdata),
        .i_raddr (nd_raddr),
        .o_rdata (nd_rdata)
    );

    // leaf set store: OR in on leaf requests, zero on clear
    always_comb begin
        lf_we    = 1'b0;
        lf_waddr = r_lf_addr;
        lf_wdata = lf_rdata | r_lf_set;
        if (r_state == ST_LEAF_WR) begin
            lf_we = r_lf_ok;
        end else if (r_state == ST_CLEAR) begin
            lf_we    = 32'(r_clr) < MAX_LEAVES;
            lf_waddr = LA'(r_clr);
            lf_wdata = '0;
        end
        lf_raddr = (r_state == ST_NODE_DAT) ? LA'(nd_rdata[W_LEAF-2:0])
                                            : LA'(i_item.leaf_id[W_LEAF-2:0]);
    end

    pcs_ram #(.WIDTH(W_CSET), .DEPTH(MAX_LEAVES)) u_leaf_mem (
        .i_clk   (i_clk),
        .i_we    (lf_we),
        .i_waddr (lf_waddr),
        .i_wdata (lf_wdata),
        .i_raddr (lf_raddr),
        .o_rdata (lf_rdata)
    );

    // vote counts and present child count per node
    always_comb begin
        wk_pc = wk_rdata[VC_W-1:0];
        for (int b = 0; b < NUM_BASES; b++) begin
            wk_vote[b] = wk_rdata[(b+1)*VC_W +: VC_W];
        end
    end

    always_comb begin
        wk_we    = 1'b0;
        wk_waddr = NA'(r_par[W_PARENT-2:0]);
        wk_wdata[VC_W-1:0] = wk_pc + VC_W'(1);
        for (int b = 0; b < NUM_BASES; b++) begin
            wk_wdata[(b+1)*VC_W +: VC_W] = wk_vote[b] + VC_W'(r_cs[b]);
        end
        if (r_state == ST_FOLD) begin
            wk_we = 1'b1;
        end else if (r_state == ST_CLEAR) begin
            wk_we    = 32'(r_clr) < MAX_NODES;
            wk_waddr = NA'(r_clr);
            wk_wdata = '0;
        end
        wk_raddr = (r_state == ST_EVAL) ? NA'(r_par[W_PARENT-2:0]) : NA'(r_v);
    end

    pcs_ram #(.WIDTH(WK_W), .DEPTH(MAX_NODES)) u_work_mem (
        .i_clk   (i_clk),
        .i_we    (wk_we),
        .i_waddr (wk_waddr),
        .i_wdata (wk_wdata),
        .i_raddr (wk_raddr),
        .o_rdata (wk_rdata)
    );

    // node evaluation: leaf set or majority vote of the children
    always_comb begin
        is_leaf = !r_raw[W_LEAF-1];
        cs_leaf = (is_leaf && (32'(r_raw[W_LEAF-2:0]) < MAX_LEAVES)) ? lf_rdata : '0;
        mx = '0;
        for (int b = 0; b < NUM_BASES; b++) begin
            if (wk_vote[b] > mx) mx = wk_vote[b];
        end
        cs_int = '0;
        for (int b = 0; b < NUM_BASES; b++) begin
            if (wk_vote[b] == mx) cs_int[b] = 1'b1;
        end
        if (is_leaf) begin
            cs_eval = cs_leaf;
        end else begin
            cs_eval = (wk_pc != '0) ? cs_int : '0;
        end
        par_ok    = !r_par[W_PARENT-1] && (32'(r_par[W_PARENT-2:0]) < MAX_NODES);
        fold      = r_pass2 && (cs_eval != '0) && par_ok;
        adv       = ((r_state == ST_EVAL) && !fold) || (r_state == ST_FOLD);
        last_node = (VC_W'(r_v + VC_W'(1)) == n_nodes);
        depth_ok  = 32'(r_depth) >= 32'(cfg.leaf_floor);
        out_free  = !r_out_valid || o_res.ready;
    end

    // sequencer, both passes end in check so the last cost update has landed
    always_comb begin
        n_state  = r_state;
        sc_start = 1'b0;
        case (r_state)
            ST_CLEAR:    if (r_clr == CW'(CD - 1)) n_state = ST_IDLE;
            ST_IDLE:     if (accept && (i_item.cmd == CMD_LEAF)) n_state = ST_LEAF_WR;
            ST_LEAF_WR: begin
                if (r_last) begin
                    n_state = (n_nodes == '0) ? ST_CHECK : ST_NODE_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_NODE_RD:  n_state = ST_NODE_DAT;
            ST_NODE_DAT: n_state = ST_EVAL;
            ST_EVAL, ST_FOLD: begin
                if (r_state == ST_EVAL && fold) begin
                    n_state = ST_FOLD;
                end else if (last_node) begin
                    n_state = ST_CHECK;
                end else begin
                    n_state = ST_NODE_RD;
                end
            end
            ST_CHECK: begin
                if (!depth_ok) begin
                    n_state = ST_EMIT;
                end else if (r_pass2 || (n_nodes == '0)) begin
                    n_state  = ST_SCORE;
                    sc_start = 1'b1;
                end else begin
                    n_state = ST_NODE_RD;
                end
            end
            ST_SCORE:    if (sc_done) n_state = ST_EMIT;
            ST_EMIT:     if (out_free) n_state = ST_CLEAR;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr <= r_clr + CW'(1);
        end else if (r_state == ST_EMIT) begin
            r_clr <= '0;
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_lf_addr <= LA'(i_item.leaf_id[W_LEAF-2:0]);
                r_lf_set  <= i_item.leaf_cset;
                r_lf_ok   <= lid_ok;
                r_last    <= i_item.last;
            end
            ST_LEAF_WR: begin
                r_v     <= '0;
                r_depth <= '0;
                r_cost  <= '0;
                r_bsum  <= '0;
                r_pass2 <= 1'b0;
            end
            ST_NODE_DAT: begin
                r_par <= nd_rdata[ND_W-1 -: W_PARENT];
                r_br  <= nd_rdata[W_LEAF +: W_BRANCH];
                r_raw <= nd_rdata[W_LEAF-1:0];
            end
            ST_EVAL: begin
                if (!r_pass2) begin
                    if (cs_leaf != '0) r_depth <= r_depth + VC_W'(1);
                end else begin
                    if (!is_leaf && (wk_pc != '0)) r_cost <= r_cost + (wk_pc - mx);
                    if (fold) begin
                        r_bsum <= r_bsum + BSUM_W'(r_br);
                        r_cs   <= cs_eval;
                    end
                end
                if (adv && !last_node) r_v <= r_v + VC_W'(1);
            end
            ST_FOLD: begin
                if (!last_node) r_v <= r_v + VC_W'(1);
            end
            ST_CHECK: begin
                r_ok    <= depth_ok;
                r_rs    <= '0;
                r_pass2 <= 1'b1;
                r_v     <= '0;
            end
            ST_SCORE: begin
                if (sc_done) r_rs <= sc_rs;
            end
            default: ;
        endcase
    end

    pcs_score #(.BSUM_W(BSUM_W), .COST_W(VC_W)) u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sc_start),
        .i_bsum  (r_bsum),
        .i_cost  (r_cost),
        .i_scale (cfg.len_mult),
        .o_done  (sc_done),
        .o_rs    (sc_rs)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_out_scored <= r_ok;
            r_out_rs     <= r_rs;
            r_out_depth  <= (32'(r_depth) > 255) ? W_DEPTH'(255) : W_DEPTH'(r_depth);
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.scored   = r_out_scored;
    assign o_res.rs_score = r_out_rs;
    assign o_res.depth    = r_out_depth;

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL && !r_pass2) |-> (r_depth <= r_v))
        else $error("depth count exceeds nodes walked");

    a_cost_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL && r_pass2) |-> (r_cost <= r_v))
        else $error("parsimony cost exceeds nodes walked");

    a_unscored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.scored) |-> (o_res.rs_score == '0))
        else $error("unscored column with nonzero score");

    a_fold_parent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FOLD) |-> ($past(r_state) == ST_EVAL && r_pass2))
        else $error("vote fold outside scoring pass");
`endif
endmodule
